@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the default clk_i / rst_ni pair.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_DEF(label, prop, msg)

`endif

`endif

@@ hdl/sscf_pkg.sv @@
// ----------------------------------------------------------------------------
// sscf_pkg
// Shared widths, register indexes and constants of the sector center fill.
// ----------------------------------------------------------------------------
package sscf_pkg;

  // Sector grid size (sectors per side).
  localparam int SECTORS_PER_SIDE = 8;

  localparam int SECTOR_IDX_W = 8;
  localparam int READING_W    = 16;
  localparam int COORD_W      = 5;
  localparam int NUM_READINGS = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 8;
  localparam int MARGIN_W   = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THRESHOLD   = 2'd0,
    CFG_CENTER_GAIN     = 2'd1,
    CFG_NEIGHBOR_MARGIN = 2'd2
  } cfg_idx_e;

  localparam logic [READING_W-1:0] LOW_THRESHOLD_RST = 16'd512;
  localparam logic [GAIN_W-1:0]    CENTER_GAIN_RST   = 8'd50;
  localparam logic [MARGIN_W-1:0]  NEIGHBOR_MARGIN_RST = 7'd20;

  // Percent arithmetic.
  localparam int SCALED_W = 24;  // gain*diff+50 and peak*(100+margin)+50
  localparam int QUOT_W   = 18;  // scaled value / 100
  localparam logic [SCALED_W-1:0]  ROUND_HALF    = 24'd50;
  localparam logic [GAIN_W-1:0]    PERCENT_SCALE = 8'd100;
  localparam logic [READING_W-1:0] VALUE_MAX     = 16'hFFFF;

  // floor(x/100) == (x * DIV100_MAGIC) >> DIV100_SHIFT, exact for x < 2**24.
  localparam int DIV100_MAGIC_W = 25;
  localparam int DIV100_SHIFT   = 31;
  localparam logic [DIV100_MAGIC_W-1:0] DIV100_MAGIC = 25'd21474837;

  typedef logic [NUM_READINGS-1:0][READING_W-1:0] readings_t;

endpackage

@@ hdl/sscf_if.sv @@
// ----------------------------------------------------------------------------
// sscf_if
// Valid/ready channels carrying sector entries in and filled sectors out.
// ----------------------------------------------------------------------------
interface sscf_in_if;
  logic                                valid;
  logic                                ready;
  logic [sscf_pkg::SECTOR_IDX_W-1:0]   sector_x;
  logic [sscf_pkg::SECTOR_IDX_W-1:0]   sector_y;
  logic [sscf_pkg::READING_W-1:0]      reading_0;
  logic [sscf_pkg::READING_W-1:0]      reading_1;
  logic [sscf_pkg::READING_W-1:0]      reading_2;
  logic [sscf_pkg::READING_W-1:0]      reading_3;
  logic [sscf_pkg::READING_W-1:0]      reading_4;
  logic [sscf_pkg::READING_W-1:0]      reading_5;
  logic [sscf_pkg::READING_W-1:0]      reading_6;
  logic [sscf_pkg::READING_W-1:0]      reading_7;

  modport source (
    output valid, sector_x, sector_y, reading_0, reading_1, reading_2, reading_3,
           reading_4, reading_5, reading_6, reading_7,
    input  ready
  );
  modport sink (
    input  valid, sector_x, sector_y, reading_0, reading_1, reading_2, reading_3,
           reading_4, reading_5, reading_6, reading_7,
    output ready
  );
endinterface

interface sscf_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [sscf_pkg::COORD_W-1:0]   base_col;
  logic [sscf_pkg::COORD_W-1:0]   base_row;
  logic [sscf_pkg::READING_W-1:0] value_x0_y0;
  logic [sscf_pkg::READING_W-1:0] value_x1_y0;
  logic [sscf_pkg::READING_W-1:0] value_x2_y0;
  logic [sscf_pkg::READING_W-1:0] value_x0_y1;
  logic [sscf_pkg::READING_W-1:0] value_x1_y1;
  logic [sscf_pkg::READING_W-1:0] value_x2_y1;
  logic [sscf_pkg::READING_W-1:0] value_x0_y2;
  logic [sscf_pkg::READING_W-1:0] value_x1_y2;
  logic [sscf_pkg::READING_W-1:0] value_x2_y2;

  modport source (
    output valid, accepted, base_col, base_row,
           value_x0_y0, value_x1_y0, value_x2_y0,
           value_x0_y1, value_x1_y1, value_x2_y1,
           value_x0_y2, value_x1_y2, value_x2_y2,
    input  ready
  );
  modport sink (
    input  valid, accepted, base_col, base_row,
           value_x0_y0, value_x1_y0, value_x2_y0,
           value_x0_y1, value_x1_y1, value_x2_y1,
           value_x0_y2, value_x1_y2, value_x2_y2,
    output ready
  );
endinterface

@@ hdl/sensor_sector_center_fill.sv @@
// ----------------------------------------------------------------------------
// sensor_sector_center_fill
// Fills the missing center of a 3x3 pressure-sensor sector from its eight
// neighbor readings.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   - one transaction per sector entry: sector column/row and the eight
//            readings r0..r7 (row-major, center missing).
//   out_o  - one transaction per entry: accepted flag, grid origin and the
//            nine cell values. Out-of-range sectors come back all zero with
//            accepted low; quiet sectors (all readings below threshold) come
//            back with the origin and nine zero values.
//   cfg_*  - register writes (threshold, gain, margin); write only while idle.
// Timing:
//   Five register stages: input, averages/peak, percent products, divide by
//   100 (reciprocal multiply), then the result register.
//   Throughput is one transaction per cycle while out_o.ready is high; each
//   stage refills as soon as the stage after it moves, so bubbles are
//   squeezed out under a stall.
// Reset:
//   All stages empty, registers at their defaults (512, 50, 20).
// Stall:
//   When out_o.ready is low the pipeline keeps filling until all five stages
//   hold an item; only then does in_i.ready drop.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_sector_center_fill (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sscf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sscf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  sscf_in_if.sink                             in_i,
  sscf_out_if.source                          out_o
);

  localparam int RW  = sscf_pkg::READING_W;
  localparam int CW  = sscf_pkg::COORD_W;
  localparam int SW  = sscf_pkg::SCALED_W;
  localparam int QW  = sscf_pkg::QUOT_W;
  localparam int PW  = SW + sscf_pkg::DIV100_MAGIC_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RW-1:0]                   low_thr_q;
  logic [sscf_pkg::GAIN_W-1:0]     gain_pct_q;
  logic [sscf_pkg::MARGIN_W-1:0]   margin_pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q    <= sscf_pkg::LOW_THRESHOLD_RST;
      gain_pct_q   <= sscf_pkg::CENTER_GAIN_RST;
      margin_pct_q <= sscf_pkg::NEIGHBOR_MARGIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sscf_pkg::CFG_LOW_THRESHOLD:   low_thr_q    <= cfg_data_i[RW-1:0];
        sscf_pkg::CFG_CENTER_GAIN:     gain_pct_q   <= cfg_data_i[sscf_pkg::GAIN_W-1:0];
        sscf_pkg::CFG_NEIGHBOR_MARGIN: margin_pct_q <= cfg_data_i[sscf_pkg::MARGIN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage payload types
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic                    acc;
    logic                    quiet;
    logic [CW-1:0]           base_col;
    logic [CW-1:0]           base_row;
  } flags_t;

  typedef struct packed {
    logic [sscf_pkg::SECTOR_IDX_W-1:0] sx;
    logic [sscf_pkg::SECTOR_IDX_W-1:0] sy;
    sscf_pkg::readings_t               rd;
  } s0_t;

  typedef struct packed {
    flags_t              fl;
    sscf_pkg::readings_t rd;
    logic [RW-1:0]       edge_avg;
    logic [RW-1:0]       corner_avg;
    logic [RW-1:0]       peak;
  } s1_t;

  typedef struct packed {
    flags_t              fl;
    sscf_pkg::readings_t rd;
    logic [RW-1:0]       edge_avg;
    logic [SW-1:0]       gain_prod;
    logic [SW-1:0]       cap_prod;
  } s2_t;

  typedef struct packed {
    flags_t              fl;
    sscf_pkg::readings_t rd;
    logic [RW-1:0]       edge_avg;
    logic [QW-1:0]       boost;
    logic [QW-1:0]       cap;
  } s3_t;

  typedef struct packed {
    flags_t              fl;
    sscf_pkg::readings_t val;  // nine cells minus center, in r0..r7 order
    logic [RW-1:0]       center;
  } res_t;

  // --------------------------------------------------------------------------
  // Handshake: each stage loads when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q, vout_q;
  logic en0, en1, en2, en3, en_out;

  assign en_out = !vout_q || out_o.ready;
  assign en3    = !v3_q || en_out;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign en0    = !v0_q || en1;

  assign in_i.ready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (en0)    v0_q   <= in_i.valid;
      if (en1)    v1_q   <= v0_q;
      if (en2)    v2_q   <= v1_q;
      if (en3)    v3_q   <= v2_q;
      if (en_out) vout_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  s0_t s0_d, s0_q;

  always_comb begin
    s0_d.sx    = in_i.sector_x;
    s0_d.sy    = in_i.sector_y;
    s0_d.rd[0] = in_i.reading_0;
    s0_d.rd[1] = in_i.reading_1;
    s0_d.rd[2] = in_i.reading_2;
    s0_d.rd[3] = in_i.reading_3;
    s0_d.rd[4] = in_i.reading_4;
    s0_d.rd[5] = in_i.reading_5;
    s0_d.rd[6] = in_i.reading_6;
    s0_d.rd[7] = in_i.reading_7;
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_i.valid) s0_q <= s0_d;
  end

  // --------------------------------------------------------------------------
  // Stage 1: range check, quiet check, origin, rounded averages, peak
  // --------------------------------------------------------------------------
  s1_t s1_d, s1_q;
  logic [sscf_pkg::SECTOR_IDX_W+1:0] col_x3, row_x3;
  logic [RW+1:0]                     side_total, corner_total;
  logic [RW-1:0]                     pk01, pk23, pk45, pk67, pk03, pk47;

  always_comb begin
    // index*3 as index + 2*index, low bits kept
    col_x3 = {2'b00, s0_q.sx} + {1'b0, s0_q.sx, 1'b0};
    row_x3 = {2'b00, s0_q.sy} + {1'b0, s0_q.sy, 1'b0};

    s1_d.fl.acc = (s0_q.sx < sscf_pkg::SECTOR_IDX_W'(sscf_pkg::SECTORS_PER_SIDE)) &&
                  (s0_q.sy < sscf_pkg::SECTOR_IDX_W'(sscf_pkg::SECTORS_PER_SIDE));
    s1_d.fl.base_col = col_x3[CW-1:0];
    s1_d.fl.base_row = row_x3[CW-1:0];

    s1_d.fl.quiet = 1'b1;
    for (int i = 0; i < sscf_pkg::NUM_READINGS; i++) begin
      if (s0_q.rd[i] >= low_thr_q) s1_d.fl.quiet = 1'b0;
    end

    side_total   = {2'b00, s0_q.rd[1]} + {2'b00, s0_q.rd[3]} +
                   {2'b00, s0_q.rd[4]} + {2'b00, s0_q.rd[6]} + (RW+2)'(2);
    corner_total = {2'b00, s0_q.rd[0]} + {2'b00, s0_q.rd[2]} +
                   {2'b00, s0_q.rd[5]} + {2'b00, s0_q.rd[7]} + (RW+2)'(2);
    s1_d.edge_avg   = side_total[RW+1:2];
    s1_d.corner_avg = corner_total[RW+1:2];

    pk01 = (s0_q.rd[1] > s0_q.rd[0]) ? s0_q.rd[1] : s0_q.rd[0];
    pk23 = (s0_q.rd[3] > s0_q.rd[2]) ? s0_q.rd[3] : s0_q.rd[2];
    pk45 = (s0_q.rd[5] > s0_q.rd[4]) ? s0_q.rd[5] : s0_q.rd[4];
    pk67 = (s0_q.rd[7] > s0_q.rd[6]) ? s0_q.rd[7] : s0_q.rd[6];
    pk03 = (pk23 > pk01) ? pk23 : pk01;
    pk47 = (pk67 > pk45) ? pk67 : pk45;
    s1_d.peak = (pk47 > pk03) ? pk47 : pk03;

    s1_d.rd = s0_q.rd;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && v0_q) s1_q <= s1_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: gain product and cap product, both pre-rounded by +50
  // --------------------------------------------------------------------------
  s2_t s2_d, s2_q;
  logic [RW-1:0]                 diff;
  logic [sscf_pkg::GAIN_W-1:0]   cap_pct;

  always_comb begin
    diff    = (s1_q.edge_avg > s1_q.corner_avg) ? (s1_q.edge_avg - s1_q.corner_avg) : '0;
    cap_pct = sscf_pkg::PERCENT_SCALE + {1'b0, margin_pct_q};

    s2_d.gain_prod = SW'(gain_pct_q) * SW'(diff) + sscf_pkg::ROUND_HALF;
    s2_d.cap_prod  = SW'(cap_pct) * SW'(s1_q.peak) + sscf_pkg::ROUND_HALF;
    s2_d.fl        = s1_q.fl;
    s2_d.rd        = s1_q.rd;
    s2_d.edge_avg  = s1_q.edge_avg;
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) s2_q <= s2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: divide both products by 100 with the reciprocal multiply
  // --------------------------------------------------------------------------
  s3_t s3_d, s3_q;
  logic [PW-1:0] gain_recip, cap_recip;

  always_comb begin
    gain_recip = PW'(s2_q.gain_prod) * PW'(sscf_pkg::DIV100_MAGIC);
    cap_recip  = PW'(s2_q.cap_prod)  * PW'(sscf_pkg::DIV100_MAGIC);

    s3_d.boost    = gain_recip[sscf_pkg::DIV100_SHIFT +: QW];
    s3_d.cap      = cap_recip[sscf_pkg::DIV100_SHIFT +: QW];
    s3_d.fl       = s2_q.fl;
    s3_d.rd       = s2_q.rd;
    s3_d.edge_avg = s2_q.edge_avg;
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) s3_q <= s3_d;
  end

  // --------------------------------------------------------------------------
  // Result stage: add, cap, saturate, then blank for out-of-range / quiet
  // --------------------------------------------------------------------------
  res_t res_d, res_q;
  logic [QW-1:0] est, capped;

  always_comb begin
    est    = QW'(s3_q.edge_avg) + s3_q.boost;
    capped = (est > s3_q.cap) ? s3_q.cap : est;

    res_d.fl     = s3_q.fl;
    res_d.val    = s3_q.rd;
    res_d.center = (capped > QW'(sscf_pkg::VALUE_MAX)) ? sscf_pkg::VALUE_MAX : capped[RW-1:0];

    if (!s3_q.fl.acc) begin
      res_d.fl.base_col = '0;
      res_d.fl.base_row = '0;
      res_d.val         = '0;
      res_d.center      = '0;
    end else if (s3_q.fl.quiet) begin
      res_d.val    = '0;
      res_d.center = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && v3_q) res_q <= res_d;
  end

  assign out_o.valid       = vout_q;
  assign out_o.accepted    = res_q.fl.acc;
  assign out_o.base_col    = res_q.fl.base_col;
  assign out_o.base_row    = res_q.fl.base_row;
  assign out_o.value_x0_y0 = res_q.val[0];
  assign out_o.value_x1_y0 = res_q.val[1];
  assign out_o.value_x2_y0 = res_q.val[2];
  assign out_o.value_x0_y1 = res_q.val[3];
  assign out_o.value_x1_y1 = res_q.center;
  assign out_o.value_x2_y1 = res_q.val[4];
  assign out_o.value_x0_y2 = res_q.val[5];
  assign out_o.value_x1_y2 = res_q.val[6];
  assign out_o.value_x2_y2 = res_q.val[7];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input backpressure only ever comes from a full pipe behind a stalled output.
  `ASSERT_DEF(a_stall_origin,
    !in_i.ready |-> (out_o.valid && !out_o.ready && v0_q && v1_q && v2_q && v3_q),
    "input stalled without a full pipe behind a stalled output")

  // An out-of-range sector is blank everywhere.
  `ASSERT_DEF(a_reject_blank,
    (out_o.valid && !out_o.accepted) |-> (out_o.base_col == '0 && out_o.base_row == '0
      && out_o.value_x1_y1 == '0 && out_o.value_x0_y0 == '0 && out_o.value_x2_y2 == '0),
    "rejected sector carries data")

  // A nonzero center needs a nonzero neighbor (cap follows the peak).
  `ASSERT_DEF(a_center_peak,
    (out_o.valid && out_o.value_x1_y1 != '0) |-> (out_o.value_x0_y0 != '0
      || out_o.value_x1_y0 != '0 || out_o.value_x2_y0 != '0 || out_o.value_x0_y1 != '0
      || out_o.value_x2_y1 != '0 || out_o.value_x0_y2 != '0 || out_o.value_x1_y2 != '0
      || out_o.value_x2_y2 != '0),
    "center exceeds a zero peak")

endmodule

@@ verif/sensor_sector_center_fill_test.sv @@
// ----------------------------------------------------------------------------
// sensor_sector_center_fill_test
// Self-checking bench for the sector center fill. Entries go in through the
// input channel under random sender gaps. Filled sectors are taken under
// random receiver stalls and compared field by field against a predictor
// kept in this file. The run steps through several register settings,
// including both extremes of every register.
// ----------------------------------------------------------------------------
module sensor_sector_center_fill_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths taken from the package
  localparam int IW = sscf_pkg::SECTOR_IDX_W;
  localparam int RW = sscf_pkg::READING_W;
  localparam int CW = sscf_pkg::COORD_W;
  localparam int DW = sscf_pkg::CFG_DATA_W;
  localparam int NR = sscf_pkg::NUM_READINGS;
  localparam int SPS = sscf_pkg::SECTORS_PER_SIDE;

  // Run control
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
  localparam int PIPE_SETTLE = 8;       // five stages plus margin
  localparam int LONG_HOLD   = 90;      // receiver hold-off, fills the pipe
  localparam int NUM_SETS    = 5;       // register settings after defaults
  localparam int SET_ITEMS   = 135;     // random entries per setting

  // One input entry and one filled sector.
  typedef struct {
    logic [IW-1:0]       sector_x;
    logic [IW-1:0]       sector_y;
    sscf_pkg::readings_t readings;
  } sector_entry_t;

  // Cells are row-major: x0y0 x1y0 x2y0 x0y1 x1y1 x2y1 x0y2 x1y2 x2y2.
  typedef struct {
    logic               accepted;
    logic [CW-1:0]      base_col;
    logic [CW-1:0]      base_row;
    logic [8:0][RW-1:0] cells;
  } sector_cells_t;

  // Shapes of random readings.
  typedef enum int {
    SHAPE_NOISE,       // all 16 bits random
    SHAPE_HILL,        // edges around a level, corners lower
    SHAPE_HILL_WIDE,   // same, counted twice so hills dominate
    SHAPE_HIGH,        // near full scale, hits the cap and saturation
    SHAPE_NEAR_QUIET,  // at or just below the threshold
    SHAPE_QUIET,       // below threshold, 0..15 if it is zero
    SHAPE_SPIKE        // small floor with one random reading
  } shape_e;

  logic clk_i;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [sscf_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [DW-1:0]                  cfg_data_i;

  sscf_in_if  in_if ();
  sscf_out_if out_if ();

  sensor_sector_center_fill u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register copies used by the predictor. Written only while idle.
  logic [RW-1:0]                 cfg_threshold = sscf_pkg::LOW_THRESHOLD_RST;
  logic [sscf_pkg::GAIN_W-1:0]   cfg_gain      = sscf_pkg::CENTER_GAIN_RST;
  logic [sscf_pkg::MARGIN_W-1:0] cfg_margin    = sscf_pkg::NEIGHBOR_MARGIN_RST;

  sector_entry_t entry_queue [$];       // entries waiting for the driver
  sector_cells_t expected_sectors [$];  // predictions in acceptance order

  int items_queued;
  int entries_sent;
  int sectors_checked;
  int mismatch_count;
  int cycle_count;
  int settings_used;
  // What the accepted entries exercised
  int n_out_of_range, n_quiet, n_gain, n_capped, n_saturated;

  logic in_took;   // input transaction at the last rising edge
  logic out_took;  // output transaction at the last rising edge

  string cell_name [9] = '{"value_x0_y0", "value_x1_y0", "value_x2_y0",
                           "value_x0_y1", "value_x1_y1", "value_x2_y1",
                           "value_x0_y2", "value_x1_y2", "value_x2_y2"};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: the nine cells of one sector under the current registers.
  // --------------------------------------------------------------------------
  function automatic sector_cells_t fill_sector(sector_entry_t entry);
    sector_cells_t res;
    int unsigned   r [NR];
    int unsigned   edge_avg, corner_avg, centre, peak, cap;
    bit            live;
    res.accepted = 1'b0;
    res.base_col = '0;
    res.base_row = '0;
    res.cells    = '0;
    // Out-of-range sector: everything zero, accepted low
    if (entry.sector_x >= SPS || entry.sector_y >= SPS) begin
      n_out_of_range++;
      return res;
    end
    live = 1'b0;
    for (int i = 0; i < NR; i++) begin
      r[i] = 32'(entry.readings[i]);
      if (entry.readings[i] >= cfg_threshold) live = 1'b1;
    end
    res.accepted = 1'b1;
    res.base_col = CW'(int'(entry.sector_x) * 3);
    res.base_row = CW'(int'(entry.sector_y) * 3);
    // Quiet sector: origin given, all cells cleared
    if (!live) begin
      n_quiet++;
      return res;
    end
    edge_avg   = (r[1] + r[3] + r[4] + r[6] + 2) / 4;
    corner_avg = (r[0] + r[2] + r[5] + r[7] + 2) / 4;
    centre     = edge_avg;
    // Gain only on a positive edge-minus-corner difference
    if (edge_avg > corner_avg) begin
      centre += (32'(cfg_gain) * (edge_avg - corner_avg) + 50) / 100;
      n_gain++;
    end
    peak = r[0];
    for (int i = 1; i < NR; i++)
      if (r[i] > peak) peak = r[i];
    cap = (peak * (100 + 32'(cfg_margin)) + 50) / 100;
    if (centre > cap) begin
      centre = cap;
      n_capped++;
    end
    if (centre > 32'(sscf_pkg::VALUE_MAX)) begin
      centre = 32'(sscf_pkg::VALUE_MAX);
      n_saturated++;
    end
    res.cells[0] = r[0][RW-1:0];
    res.cells[1] = r[1][RW-1:0];
    res.cells[2] = r[2][RW-1:0];
    res.cells[3] = r[3][RW-1:0];
    res.cells[4] = centre[RW-1:0];
    res.cells[5] = r[4][RW-1:0];
    res.cells[6] = r[5][RW-1:0];
    res.cells[7] = r[6][RW-1:0];
    res.cells[8] = r[7][RW-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [RW-1:0] clip16(int v);
    if (v < 0) return '0;
    if (v > int'(sscf_pkg::VALUE_MAX)) return sscf_pkg::VALUE_MAX;
    return v[RW-1:0];
  endfunction

  // Corners share one value, edges another.
  function automatic sector_entry_t ring(int x, int y, int corner, int side);
    sector_entry_t e;
    e.sector_x = x[IW-1:0];
    e.sector_y = y[IW-1:0];
    for (int i = 0; i < NR; i++)
      e.readings[i] = (i inside {1, 3, 4, 6}) ? clip16(side) : clip16(corner);
    return e;
  endfunction

  function automatic sector_entry_t make_random_entry();
    sector_entry_t e;
    int unsigned   pick, level, low, base, spread;
    shape_e        shape;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // full index range, mostly rejected
      e.sector_x = IW'($urandom);
      e.sector_y = IW'($urandom);
    end else if (pick < 13) begin
      // one index just or far out of range
      e.sector_x = IW'($urandom_range(SPS, 255));
      e.sector_y = IW'($urandom_range(0, SPS - 1));
      if (pick[0]) {e.sector_x, e.sector_y} = {e.sector_y, e.sector_x};
    end else begin
      e.sector_x = IW'($urandom_range(0, SPS - 1));
      e.sector_y = IW'($urandom_range(0, SPS - 1));
    end
    shape = shape_e'($urandom_range(0, int'(SHAPE_SPIKE)));
    level = $urandom_range(0, 65535) >> $urandom_range(0, 12);
    low   = $urandom_range(0, level);
    for (int i = 0; i < NR; i++) begin
      case (shape)
        SHAPE_HILL, SHAPE_HILL_WIDE: begin
          base   = (i inside {1, 3, 4, 6}) ? level : low;
          spread = base / 8 + 1;
          e.readings[i] = clip16(int'(base) + int'($urandom_range(0, 2 * spread))
                                 - int'(spread));
        end
        SHAPE_HIGH:       e.readings[i] = RW'($urandom_range(61440, 65535));
        SHAPE_NEAR_QUIET: e.readings[i] = clip16(int'(cfg_threshold)
                                                 - int'($urandom_range(0, 8)));
        SHAPE_QUIET:      e.readings[i] = (cfg_threshold == '0) ? RW'($urandom_range(0, 15))
                                          : RW'($urandom_range(0, int'(cfg_threshold) - 1));
        SHAPE_SPIKE:      e.readings[i] = RW'($urandom_range(0, 255));
        default:          e.readings[i] = RW'($urandom);
      endcase
    end
    if (shape == SHAPE_SPIKE) e.readings[$urandom_range(0, NR - 1)] = RW'($urandom);
    return e;
  endfunction

  task automatic queue_entry(sector_entry_t e);
    entry_queue.push_back(e);
    items_queued++;
  endtask

  // Per-item wait, drawn at random, with occasional runs of zero wait.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run_left = $urandom_range(8, 40);
    return $urandom_range(0, 13);
  endfunction

  // Block until every queued entry has come back, then let the pipe settle.
  task automatic wait_for_results();
    while (sectors_checked != items_queued) @(negedge clk_i);
    repeat (PIPE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(sscf_pkg::cfg_idx_e idx, logic [DW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      sscf_pkg::CFG_LOW_THRESHOLD:   cfg_threshold = value;
      sscf_pkg::CFG_CENTER_GAIN:     cfg_gain      = value[sscf_pkg::GAIN_W-1:0];
      sscf_pkg::CFG_NEIGHBOR_MARGIN: cfg_margin    = value[sscf_pkg::MARGIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic flag_mismatch(string field, logic [RW-1:0] got, logic [RW-1:0] want);
    mismatch_count++;
    $display("MISMATCH sector %0d %s: got %h expected %h",
             sectors_checked, field, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued entries at the falling edge. After each
  // transaction it idles for a drawn number of cycles. valid gets a single
  // assignment per edge so back-to-back entries keep it high.
  // --------------------------------------------------------------------------
  bit            offering;
  int            gap_left;
  int            send_run;
  sector_entry_t cur_entry;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_took) begin
        offering = 1'b0;
        gap_left = draw_wait(send_run);
      end
      if (!offering && gap_left > 0) begin
        gap_left--;
      end else if (!offering && entry_queue.size() != 0) begin
        cur_entry = entry_queue.pop_front();
        offering  = 1'b1;
        in_if.sector_x  <= cur_entry.sector_x;
        in_if.sector_y  <= cur_entry.sector_y;
        in_if.reading_0 <= cur_entry.readings[0];
        in_if.reading_1 <= cur_entry.readings[1];
        in_if.reading_2 <= cur_entry.readings[2];
        in_if.reading_3 <= cur_entry.readings[3];
        in_if.reading_4 <= cur_entry.readings[4];
        in_if.reading_5 <= cur_entry.readings[5];
        in_if.reading_6 <= cur_entry.readings[6];
        in_if.reading_7 <= cur_entry.readings[7];
      end
      in_if.valid <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls a drawn number of cycles after each result. Twice in the
  // run it holds ready low for a long stretch while the driver keeps sending,
  // so the pipeline fills completely and backs up onto the input.
  // --------------------------------------------------------------------------
  int stall_left;
  int hold_left;
  int recv_run;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_took) begin
        stall_left = draw_wait(recv_run);
        if (sectors_checked == 60 || sectors_checked == 420) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at the rising edge, predicts every accepted entry and checks
  // every accepted sector against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sector_entry_t seen;
    sector_cells_t got, want;
    cycle_count++;
    if (!rst_ni) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_if.valid && in_if.ready;
      out_took <= out_if.valid && out_if.ready;
      if (in_if.valid && in_if.ready) begin
        seen.sector_x    = in_if.sector_x;
        seen.sector_y    = in_if.sector_y;
        seen.readings[0] = in_if.reading_0;
        seen.readings[1] = in_if.reading_1;
        seen.readings[2] = in_if.reading_2;
        seen.readings[3] = in_if.reading_3;
        seen.readings[4] = in_if.reading_4;
        seen.readings[5] = in_if.reading_5;
        seen.readings[6] = in_if.reading_6;
        seen.readings[7] = in_if.reading_7;
        expected_sectors.push_back(fill_sector(seen));
        entries_sent++;
      end
      if (out_if.valid && out_if.ready) begin
        got.accepted = out_if.accepted;
        got.base_col = out_if.base_col;
        got.base_row = out_if.base_row;
        got.cells    = {out_if.value_x2_y2, out_if.value_x1_y2, out_if.value_x0_y2,
                        out_if.value_x2_y1, out_if.value_x1_y1, out_if.value_x0_y1,
                        out_if.value_x2_y0, out_if.value_x1_y0, out_if.value_x0_y0};
        if (expected_sectors.size() == 0) begin
          flag_mismatch("transaction with no entry pending", got.cells[4], '0);
        end else begin
          want = expected_sectors.pop_front();
          if (got.accepted !== want.accepted)
            flag_mismatch("accepted", RW'(got.accepted), RW'(want.accepted));
          if (got.base_col !== want.base_col)
            flag_mismatch("base_col", RW'(got.base_col), RW'(want.base_col));
          if (got.base_row !== want.base_row)
            flag_mismatch("base_row", RW'(got.base_row), RW'(want.base_row));
          for (int c = 0; c < 9; c++)
            if (got.cells[c] !== want.cells[c])
              flag_mismatch(cell_name[c], got.cells[c], want.cells[c]);
          sectors_checked <= sectors_checked + 1;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d sectors back",
               cycle_count, sectors_checked, items_queued);
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed entries at the reset defaults, then random
  // entries under each register setting. Registers change only once the
  // block has drained.
  // --------------------------------------------------------------------------
  initial begin
    sector_entry_t e;
    int unsigned   thr_set [NUM_SETS];
    int unsigned   gain_set [NUM_SETS];
    int unsigned   margin_set [NUM_SETS];

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.sector_x  = '0;
    in_if.sector_y  = '0;
    in_if.reading_0 = '0;
    in_if.reading_1 = '0;
    in_if.reading_2 = '0;
    in_if.reading_3 = '0;
    in_if.reading_4 = '0;
    in_if.reading_5 = '0;
    in_if.reading_6 = '0;
    in_if.reading_7 = '0;
    out_if.ready = 1'b0;
    clk_i        = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(negedge clk_i);
    settings_used = 1;

    // Directed entries, reset defaults (threshold 512, gain 50, margin 20)
    queue_entry(ring(0, 0, 0, 0));              // quiet, all zero
    queue_entry(ring(7, 7, 65535, 65535));      // last sector, full scale
    queue_entry(ring(8, 0, 1000, 2000));        // column just out of range
    queue_entry(ring(0, 8, 1000, 2000));        // row just out of range
    queue_entry(ring(255, 255, 65535, 65535));  // every index bit set
    queue_entry(ring(3, 5, 511, 511));          // one below threshold: quiet
    e = ring(5, 3, 511, 511);
    e.readings[7] = 16'd512;                    // one corner at threshold: live
    queue_entry(e);
    queue_entry(ring(1, 2, 0, 40000));          // strong ridge, capped by margin
    queue_entry(ring(2, 1, 900, 1000));         // gain applied, below cap
    queue_entry(ring(4, 6, 3000, 1000));        // corners above edges: no gain
    queue_entry(ring(6, 4, 0, 65535));          // past full scale: saturates
    e = ring(0, 7, 0, 0);
    e.readings[1] = 16'd513;
    e.readings[3] = 16'd1;                      // edge average rounds up
    queue_entry(e);
    e = ring(7, 0, 0, 0);
    e.readings[1] = 16'd513;                    // edge average rounds down
    queue_entry(e);
    e = ring(7, 0, 0, 0);
    e.readings[0] = 16'hFFFF;                   // lone corner spike
    queue_entry(e);

    // Random entries at the defaults, with one full pause of the sender
    for (int n = 0; n < SET_ITEMS / 2; n++) queue_entry(make_random_entry());
    wait_for_results();
    for (int n = 0; n < SET_ITEMS / 2; n++) queue_entry(make_random_entry());

    // Register settings: both extremes, a mid set, then two random sets
    thr_set[0] = 0;     gain_set[0] = 0;   margin_set[0] = 0;
    thr_set[1] = 65535; gain_set[1] = 255; margin_set[1] = 127;
    thr_set[2] = 1;     gain_set[2] = 200; margin_set[2] = 100;
    thr_set[3] = $urandom_range(0, 65535);
    gain_set[3] = $urandom_range(0, 255);
    margin_set[3] = $urandom_range(0, 127);
    thr_set[4] = $urandom_range(0, 2047);
    gain_set[4] = $urandom_range(0, 200);
    margin_set[4] = $urandom_range(0, 100);

    for (int p = 0; p < NUM_SETS; p++) begin
      wait_for_results();
      write_reg(sscf_pkg::CFG_LOW_THRESHOLD, DW'(thr_set[p]));
      write_reg(sscf_pkg::CFG_CENTER_GAIN, DW'(gain_set[p]));
      write_reg(sscf_pkg::CFG_NEIGHBOR_MARGIN, DW'(margin_set[p]));
      settings_used++;
      for (int n = 0; n < SET_ITEMS; n++) queue_entry(make_random_entry());
    end

    wait_for_results();
    repeat (2 * PIPE_SETTLE) @(negedge clk_i);

    $display("Ran %0d entries over %0d register settings in %0d cycles",
             entries_sent, settings_used, cycle_count);
    $display("Rejected %0d, quiet %0d, gain %0d, capped %0d, saturated %0d, mismatches %0d",
             n_out_of_range, n_quiet, n_gain, n_capped, n_saturated, mismatch_count);
    if (mismatch_count == 0 && expected_sectors.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sscf_pkg.sv
hdl/sscf_if.sv
hdl/sensor_sector_center_fill.sv
verif/sensor_sector_center_fill_test.sv
